// File: sv/bxr_pkg.sv
`timescale 1ns / 1ps
// Package for the bounded xorshift generator: mode and register codes,
// controller/datapath command and status types, and the generator step functions.
// Depends on nothing.
package bxr_pkg;

  localparam int WORD_W  = 32;
  localparam int WIDE_W  = 64;
  localparam int MODE_W  = 3;
  localparam int CIDX_W  = 2;

  localparam logic [MODE_W-1:0] MODE_RAW32   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RAW64   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UPTO32  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPTO64  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BELOW32 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BELOW64 = 3'd5;

  localparam logic [CIDX_W-1:0] REG_SEED_LOW  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SEED_HIGH = 2'd1;

  localparam logic [WIDE_W-1:0] SEED_LOW_RST  = 64'd1;
  localparam logic [WIDE_W-1:0] SEED_HIGH_RST = 64'd0;

  typedef struct packed {
    logic cfg_we;
    logic capture;
    logic prep;
    logic step;
    logic load_out;
  } bxr_cmd_t;

  typedef struct packed {
    logic skip;
    logic fit;
  } bxr_sts_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [3:0] gen_state_t;

  function automatic logic [WIDE_W-1:0] bxr_smear(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return m;
  endfunction

  function automatic gen_state_t bxr_next32(input gen_state_t g);
    word_t t;
    gen_state_t n;
    t = g[0] ^ (g[0] << 11);
    n[0] = g[1];
    n[1] = g[2];
    n[2] = g[3];
    n[3] = (t ^ (t >> 8)) ^ (g[3] ^ (g[3] >> 19));
    return n;
  endfunction

  function automatic gen_state_t bxr_next64(input gen_state_t g);
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    logic [WIDE_W-1:0] nb;
    gen_state_t n;
    a = {g[1], g[0]};
    b = {g[3], g[2]};
    a = a ^ (a << 23);
    nb = a ^ b ^ (a >> 18) ^ (b >> 5);
    n[0] = b[31:0];
    n[1] = b[63:32];
    n[2] = nb[31:0];
    n[3] = nb[63:32];
    return n;
  endfunction

endpackage

// File: sv/bxr_datapath.sv
`timescale 1ns / 1ps
// Datapath: generator state, bound and mask registers, draw check and result register.
// Depends on bxr_pkg; driven by bxr_ctrl commands.
module bxr_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bxr_pkg::bxr_cmd_t                     cmd,
  output bxr_pkg::bxr_sts_t                     sts,
  input  logic [bxr_pkg::MODE_W-1:0]            in_mode,
  input  logic [bxr_pkg::WIDE_W-1:0]            in_limit,
  input  logic [bxr_pkg::CIDX_W-1:0]            cfg_index,
  input  logic [bxr_pkg::WIDE_W-1:0]            cfg_data,
  output logic [bxr_pkg::WIDE_W-1:0]            out_number
);

  bxr_pkg::gen_state_t gen_r, gen_nxt;
  bxr_pkg::gen_state_t gen32;
  logic [bxr_pkg::WIDE_W-1:0] bound_r, bound_nxt;
  logic [bxr_pkg::WIDE_W-1:0] mask_r;
  logic [bxr_pkg::WIDE_W-1:0] number_r;
  logic wide_r, wide_nxt;
  logic skip_r, skip_nxt;
  logic [bxr_pkg::WIDE_W-1:0] lim32;
  logic [bxr_pkg::WIDE_W-1:0] draw;
  logic [bxr_pkg::WIDE_W-1:0] cand;

  assign lim32 = (|in_limit[63:32]) ? {32'd0, 32'hFFFF_FFFF} : {32'd0, in_limit[31:0]};

  always_comb begin
    bound_nxt = '1;
    wide_nxt  = 1'b0;
    skip_nxt  = 1'b0;
    unique case (in_mode)
      bxr_pkg::MODE_RAW32: begin
        bound_nxt = {32'd0, 32'hFFFF_FFFF};
      end
      bxr_pkg::MODE_RAW64: begin
        wide_nxt = 1'b1;
      end
      bxr_pkg::MODE_UPTO32: begin
        bound_nxt = lim32;
        skip_nxt  = (lim32 == '0);
      end
      bxr_pkg::MODE_UPTO64: begin
        bound_nxt = in_limit;
        wide_nxt  = 1'b1;
        skip_nxt  = (in_limit == '0);
      end
      bxr_pkg::MODE_BELOW32: begin
        bound_nxt = lim32 - 64'd1;
        skip_nxt  = (lim32[63:1] == '0);
      end
      bxr_pkg::MODE_BELOW64: begin
        bound_nxt = in_limit - 64'd1;
        wide_nxt  = 1'b1;
        skip_nxt  = (in_limit[63:1] == '0);
      end
      default: begin
        skip_nxt = 1'b1;
      end
    endcase
  end

  assign gen32 = bxr_pkg::bxr_next32(gen_r);
  assign draw = wide_r ? ({gen_r[1], gen_r[0]} + {gen_r[3], gen_r[2]})
                       : {32'd0, gen32[3]};
  assign cand = draw & mask_r;

  assign sts.skip = skip_r;
  assign sts.fit  = (cand <= bound_r);

  always_comb begin
    gen_nxt = gen_r;
    if (cmd.cfg_we) begin
      unique case (cfg_index)
        bxr_pkg::REG_SEED_LOW: begin
          gen_nxt[0] = cfg_data[31:0];
          gen_nxt[1] = cfg_data[63:32];
        end
        bxr_pkg::REG_SEED_HIGH: begin
          gen_nxt[2] = cfg_data[31:0];
          gen_nxt[3] = cfg_data[63:32];
        end
        default: begin
          gen_nxt = gen_r;
        end
      endcase
    end else if (cmd.step) begin
      gen_nxt = wide_r ? bxr_pkg::bxr_next64(gen_r) : gen32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r[0] <= bxr_pkg::SEED_LOW_RST[31:0];
      gen_r[1] <= bxr_pkg::SEED_LOW_RST[63:32];
      gen_r[2] <= bxr_pkg::SEED_HIGH_RST[31:0];
      gen_r[3] <= bxr_pkg::SEED_HIGH_RST[63:32];
    end else begin
      gen_r <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bound_r <= bound_nxt;
      wide_r  <= wide_nxt;
      skip_r  <= skip_nxt;
    end
    if (cmd.prep) begin
      mask_r <= bxr_pkg::bxr_smear(bound_r);
    end
    if (cmd.load_out) begin
      number_r <= skip_r ? '0 : cand;
    end
  end

  assign out_number = number_r;

endmodule

// File: sv/bxr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: input and configuration handshakes, draw loop and result valid.
// Depends on bxr_pkg; commands bxr_datapath.
module bxr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  bxr_pkg::bxr_sts_t sts,
  output bxr_pkg::bxr_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DRAW = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic done;

  assign out_free = !out_valid_r || out_ready;
  assign done     = sts.skip || sts.fit;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.cfg_we   = cfg_valid && (state_r == ST_IDLE);
    cmd.capture  = 1'b0;
    cmd.prep     = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        if (done) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            cmd.step     = !sts.skip;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/bounded_xorshift_rng_core.sv
`timescale 1ns / 1ps
// Bounded xorshift128 / xorshift128+ generator, top level; uses bxr_pkg, bxr_ctrl, bxr_datapath.
// An item passes from acceptance through the prep state into the draw loop, which makes
// generator draws, one per cycle, until one fits (at least one; a zero result takes no draw).
// The next word is accepted in the cycle after the result is registered; the draw loop, one
// generator step per cycle, sets the rate unless a held result without out_ready stalls it.
// Synchronous reset loads the state words with 1, 0, 0, 0.
module bounded_xorshift_rng_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bxr_pkg::MODE_W-1:0]         in_mode,
  input  logic [bxr_pkg::WIDE_W-1:0]         in_limit,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bxr_pkg::WIDE_W-1:0]         out_number,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bxr_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [bxr_pkg::WIDE_W-1:0]         cfg_data
);

  bxr_pkg::bxr_cmd_t cmd;
  bxr_pkg::bxr_sts_t sts;

  bxr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bxr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_mode),
    .in_limit   (in_limit),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_number (out_number)
  );

endmodule
